// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define LRU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, also during reset
`define LRU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lru_pkg.sv =====
// types and constants of the lru replacement tracker
package lru_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int KEY_W        = 16;
  localparam int CNT_W        = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_VICTIM = 2'd1,
    OP_ERASE  = 2'd2
  } lru_op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } lru_status_e;

  typedef struct packed {
    lru_op_e           op;
    logic [KEY_W-1:0]  key;
  } lru_req_t;

  typedef struct packed {
    lru_status_e       status;
    logic [KEY_W-1:0]  victim_key;
    logic [CNT_W-1:0]  entry_count;
  } lru_res_t;

  typedef struct packed {
    logic seek;
    logic load;
  } lru_cell_ctrl_t;

endpackage

// ===== hw/rtl/lru_cell.sv =====
// one recency slot: holds a key, matches it and shifts down from its upper neighbor
module lru_cell #(
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lru_pkg::lru_cell_ctrl_t ctrl_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [KEY_BITS-1:0]    nxt_key_i,
  input  logic                   nxt_valid_i,
  input  logic                   shift_i,
  output logic                   shift_o,
  output logic                   hit_o,
  output logic [KEY_BITS-1:0]    key_o,
  output logic                   valid_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                valid_q, valid_d;
  logic                hit;
  logic                shift_here;

  assign hit        = valid_q && (key_q == key_i);
  // once a gap opens below or here, every slot above pulls from its neighbor
  assign shift_here = shift_i | (ctrl_i.seek & hit);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      key_d   = key_i;
      valid_d = 1'b1;
    end else if (shift_here) begin
      key_d   = nxt_key_i;
      valid_d = nxt_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign shift_o = shift_here;
  assign hit_o   = hit;
  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

// ===== hw/rtl/lru_replacement_tracker.sv =====
// top level of the lru replacement tracker: row of recency cells and command decode
//
// Keeps up to ENTRIES distinct keys in recency order, slot 0 the least recent.
// Command channel: req_i (op, key) is taken at a rising edge with start_i high
// and busy_o low. busy_o stays low, so one command is taken every cycle.
// Ops: insert moves a held key to the most-recent end or appends a new one
// (rejected with full status when the set is full), victim removes and
// returns the least-recent key, erase removes a given key.
// Result channel: res_o (status, victim_key, entry_count) is shown for one
// cycle with done_o high, the cycle after the command is taken; throughput
// one command per cycle. All cells compare the key in parallel and
// the slots above a hit or the victim slot shift down by one in the same edge;
// the OR chain through the cells sets the cycle time.
// Reset clears every valid bit and the count at once; no clearing pass is
// needed, keys of empty slots are never used. The receiver cannot stall and
// must take each result in the cycle it is shown.
module lru_replacement_tracker #(
  parameter int ENTRIES  = lru_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  lru_pkg::lru_req_t req_i,
  output logic              done_o,
  output lru_pkg::lru_res_t res_o
);

  localparam int CntW   = $clog2(ENTRIES + 1);
  localparam int KeyMin = (KEY_BITS < lru_pkg::KEY_W) ? KEY_BITS : lru_pkg::KEY_W;
  localparam int CntMin = (CntW < lru_pkg::CNT_W) ? CntW : lru_pkg::CNT_W;

  logic                    accept;
  logic [KEY_BITS-1:0]     k;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         tgt;
  logic                    seek, wr_go, victim_go;
  logic                    any_hit, full;
  lru_pkg::lru_status_e    status;
  logic [KEY_BITS-1:0]     vkey;

  logic [ENTRIES-1:0]      hit_vec;
  logic [ENTRIES:0]        shift_chain;
  logic [KEY_BITS-1:0]     key_arr   [ENTRIES+1];
  logic [ENTRIES:0]        valid_arr;
  lru_pkg::lru_cell_ctrl_t ctrl      [ENTRIES];

  lru_pkg::lru_res_t       res_d, res_q;
  logic                    done_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_comb begin
    k = '0;
    for (int b = 0; b < KeyMin; b++) begin
      k[b] = req_i.key[b];
    end
  end

  assign any_hit = |hit_vec;
  assign full    = (cnt_q == CntW'(ENTRIES));

  always_comb begin
    seek      = 1'b0;
    wr_go     = 1'b0;
    victim_go = 1'b0;
    tgt       = cnt_q;
    cnt_d     = cnt_q;
    status    = lru_pkg::ST_MISS;
    vkey      = '0;
    if (accept) begin
      case (req_i.op)
        lru_pkg::OP_INSERT: begin
          seek = 1'b1;
          if (any_hit) begin
            // held key: slots above it shift down, key lands in the top slot
            wr_go  = 1'b1;
            tgt    = cnt_q - CntW'(1);
            status = lru_pkg::ST_DONE;
          end else if (full) begin
            status = lru_pkg::ST_FULL;
          end else begin
            wr_go  = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
            status = lru_pkg::ST_DONE;
          end
        end
        lru_pkg::OP_VICTIM: begin
          if (cnt_q != '0) begin
            victim_go = 1'b1;
            vkey      = key_arr[0];
            cnt_d     = cnt_q - CntW'(1);
            status    = lru_pkg::ST_DONE;
          end
        end
        lru_pkg::OP_ERASE: begin
          seek = 1'b1;
          if (any_hit) begin
            cnt_d  = cnt_q - CntW'(1);
            status = lru_pkg::ST_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // victim pulls the whole row down from slot 0
  assign shift_chain[0]    = victim_go;
  assign key_arr[ENTRIES]  = '0;
  assign valid_arr[ENTRIES] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign ctrl[i].seek = seek;
    assign ctrl[i].load = wr_go && (tgt == CntW'(i));

    lru_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[i]),
      .key_i       (k),
      .nxt_key_i   (key_arr[i+1]),
      .nxt_valid_i (valid_arr[i+1]),
      .shift_i     (shift_chain[i]),
      .shift_o     (shift_chain[i+1]),
      .hit_o       (hit_vec[i]),
      .key_o       (key_arr[i]),
      .valid_o     (valid_arr[i])
    );
  end

  always_comb begin
    res_d             = '0;
    res_d.status      = status;
    for (int b = 0; b < KeyMin; b++) begin
      res_d.victim_key[b] = vkey[b];
    end
    for (int b = 0; b < CntMin; b++) begin
      res_d.entry_count[b] = cnt_d[b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/lru_checker.sv =====
// port-level checks of the lru replacement tracker, bound to the top level
`include "assert_macros.svh"

module lru_checker #(
  parameter int ENTRIES = lru_pkg::ENTRIES_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input lru_pkg::lru_req_t req_i,
  input logic              done_o,
  input lru_pkg::lru_res_t res_o
);

  logic                      accept;
  logic [lru_pkg::CNT_W-1:0] full_cnt;

  assign accept   = start_i & ~busy_o & (req_i.op == req_i.op);
  assign full_cnt = lru_pkg::CNT_W'(ENTRIES);

  `LRU_ASSERT(a_one_result, clk_i, rst_ni, accept |=> done_o, "accepted beat gave no result")
  `LRU_ASSERT(a_no_extra, clk_i, rst_ni, done_o |-> $past(accept), "result without a command")
  `LRU_ASSERT(a_full_cnt, clk_i, rst_ni, (done_o && res_o.status == lru_pkg::ST_FULL) |-> (res_o.entry_count == full_cnt), "full status with a set that is not full")
  `LRU_ASSERT(a_vkey_zero, clk_i, rst_ni, (done_o && res_o.status != lru_pkg::ST_DONE) |-> (res_o.victim_key == '0), "victim key set on a failed op")
  `LRU_ASSERT(a_cnt_step, clk_i, rst_ni, (done_o && $past(done_o)) |-> ((res_o.entry_count == $past(res_o.entry_count)) || (res_o.entry_count == lru_pkg::CNT_W'($past(res_o.entry_count) + 1'b1)) || (res_o.entry_count == lru_pkg::CNT_W'($past(res_o.entry_count) - 1'b1))), "count moved by more than one")

endmodule

bind lru_replacement_tracker lru_checker #(
  .ENTRIES (ENTRIES)
) u_lru_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

// ===== test/tb_lru_replacement_tracker.sv =====
// testbench for the lru replacement tracker: directed and random commands against a recency list
`timescale 1ns / 1ps

module tb_lru_replacement_tracker;
  import lru_pkg::*;

  localparam int DEPTH = ENTRIES_DEF;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS_DEF) - 1);
  localparam lru_op_e OP_UNUSED = lru_op_e'(2'b11);
  localparam int POOL_SIZE = 24;
  localparam int CYCLE_LIMIT = 40000;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  lru_req_t req_i = '0;
  logic busy_o;
  logic done_o;
  lru_res_t res_o;

  // keys held, index 0 is the least recent
  logic [KEY_W-1:0] recency_q[$];
  lru_res_t expected_results[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int error_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  lru_replacement_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lru_replacement_tracker failed");
      $finish;
    end
  end

  function automatic lru_res_t predict_command(input lru_req_t req);
    lru_res_t res;
    logic [KEY_W-1:0] k;
    int hit;
    res = '0;
    res.status = ST_MISS;
    k = req.key & KEY_MASK;
    hit = -1;
    foreach (recency_q[i]) begin
      if (hit < 0 && recency_q[i] == k) hit = i;
    end
    case (req.op)
      OP_INSERT: begin
        if (hit >= 0) begin
          recency_q.delete(hit);
          recency_q.push_back(k);
          res.status = ST_DONE;
        end else if (recency_q.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          recency_q.push_back(k);
          res.status = ST_DONE;
        end
      end
      OP_VICTIM: begin
        if (recency_q.size() > 0) begin
          res.victim_key = recency_q.pop_front();
          res.status = ST_DONE;
        end
      end
      OP_ERASE: begin
        if (hit >= 0) begin
          recency_q.delete(hit);
          res.status = ST_DONE;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(recency_q.size());
    return res;
  endfunction

  task automatic note_mismatch(input string what, input lru_res_t want, input lru_res_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch, %s: expected status %0d victim_key %h count %0d",
               what, want.status, want.victim_key, want.entry_count);
      $display("  got status %0d victim_key %h count %0d at cycle %0d",
               got.status, got.victim_key, got.entry_count, cycle_count);
    end
  endtask

  // predict on each accepted command, then check any result beat against the oldest prediction
  always @(posedge clk_i) begin : result_check
    lru_res_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_results.push_back(predict_command(req_i));
      if (done_o) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected beat", '0, res_o);
        end else begin
          want = expected_results.pop_front();
          if (res_o.status !== want.status || res_o.victim_key !== want.victim_key ||
              res_o.entry_count !== want.entry_count)
            note_mismatch("result", want, res_o);
        end
      end
    end
  end

  task automatic send_command(input lru_op_e op, input logic [KEY_W-1:0] key);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{op: op, key: key};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic test_empty_and_unused();
    send_command(OP_VICTIM, 16'h0000);
    send_command(OP_ERASE, 16'hFFFF);
    send_command(OP_UNUSED, 16'hFFFF);
  endtask

  task automatic test_touch_and_erase();
    send_command(OP_INSERT, 16'h0000);
    send_command(OP_INSERT, 16'hFFFF);
    // touch moves the low key behind the high one
    send_command(OP_INSERT, 16'h0000);
    send_command(OP_ERASE, 16'h1234);
    send_command(OP_ERASE, 16'hFFFF);
    send_command(OP_UNUSED, 16'h0000);
    send_command(OP_VICTIM, 16'hFFFF);
  endtask

  task automatic test_full_set();
    for (int i = 0; i < DEPTH; i++) send_command(OP_INSERT, KEY_W'(i * 16'h1000) ^ 16'h0AA5);
    send_command(OP_INSERT, 16'h5A5A);
    // held key is still touched when the set is full
    send_command(OP_INSERT, 16'h5000 ^ 16'h0AA5);
    send_command(OP_VICTIM, 16'h0000);
  endtask

  task automatic run_random_phase(input int items, input int w_ins, input int w_vic);
    int sent;
    int pick;
    lru_op_e op;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 4) begin
        send_command(OP_UNUSED, key);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < w_ins) op = OP_INSERT;
        else if (pick < w_ins + w_vic) op = OP_VICTIM;
        else op = OP_ERASE;
        send_command(op, key);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    run_random_phase(110, 75, 10);
    run_random_phase(110, 45, 25);
    gaps_on = 1'b0;
    run_random_phase(110, 60, 20);
    gaps_on = 1'b1;
    run_random_phase(100, 30, 20);
    run_random_phase(90, 20, 60);
    run_random_phase(100, 85, 5);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_unused();
    test_touch_and_erase();
    test_full_set();
    test_random_traffic();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_lru_replacement_tracker passed");
    end else begin
      $display("tb_lru_replacement_tracker failed");
    end
    $finish;
  end

endmodule
